FILE: rtl/overwrite_ring_buffer_peek_top_defines.svh
// Assertion macros for the overwrite ring buffer with peek access.
// Used by overwrite_ring_buffer_peek_top; no other dependencies.
`ifndef OVERWRITE_RING_BUFFER_PEEK_TOP_DEFINES_SVH
`define OVERWRITE_RING_BUFFER_PEEK_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define ORBP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define ORBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/orbp_pkg.sv
// Shared types and constants for the overwrite ring buffer with peek access.
// No dependencies; imported by overwrite_ring_buffer_peek_top.
`default_nettype none

package orbp_pkg;

   localparam int DEPTH        = 64;
   localparam int SAMPLE_WIDTH = 48;
   localparam int IDX_W        = $clog2(DEPTH);
   localparam int LVL_W        = $clog2(DEPTH + 1);
   localparam int OP_W         = 2;
   localparam int OFF_W        = 6;

   // Operation codes; the fourth code is unused and leaves state alone
   typedef enum logic [OP_W-1:0] {
      OP_PUSH        = 2'd0,
      OP_PEEK_NEWEST = 2'd1,
      OP_PEEK_OLDEST = 2'd2
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]         operation;
      logic [SAMPLE_WIDTH-1:0] sample;
      logic [OFF_W-1:0]        offset;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] read_data;
      logic                    status;
      logic                    overwrote;
      logic [LVL_W-1:0]        fill_level;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/overwrite_ring_buffer_peek_top.sv
// Overwrite ring buffer with peek: the rsp beat is registered and appears in the cycle after the req beat.
// Throughput 1 beat per cycle; a new req is taken in the cycle the pending
// rsp is taken. Each push or in-range peek is one access to the single-port sample
// memory (synchronous read, data registered in the cycle after the address).
// Synchronous active-high reset: buffer empty, capacity 64; memory contents
// are not cleared and only entries written since the last emptying are read.
`default_nettype none

module overwrite_ring_buffer_peek_top (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  orbp_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output orbp_pkg::rsp_type     rsp_data,
   input  wire                   csr_wr_en,
   input  wire [orbp_pkg::LVL_W-1:0] csr_wr_data
);

   import orbp_pkg::*;

   // Sample memory and its registered read port
   logic [SAMPLE_WIDTH-1:0] mem [DEPTH];
   logic [SAMPLE_WIDTH-1:0] rd_data_ff;

   // Pointer state
   logic [LVL_W-1:0] capacity_ff, capacity_in;
   logic [IDX_W-1:0] write_idx_ff, write_idx_in;
   logic [IDX_W-1:0] oldest_idx_ff, oldest_idx_in;
   logic [LVL_W-1:0] fill_ff, fill_in;

   // Response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_mem_ff, rsp_mem_in;

   logic             req_fire;
   logic             mem_wr;
   logic             mem_rd;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] write_next;
   logic [IDX_W-1:0] oldest_next;
   logic [IDX_W+1:0] newest_sum;
   logic [IDX_W+1:0] oldest_sum;
   logic [IDX_W+1:0] cap_wide;
   logic             out_of_range;
   logic             is_full;
   logic [LVL_W-1:0] cap_clamped;
   op_type           op;

   assign op       = op_type'(req_data.operation);
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire = req_valid & req_ready;

   // Advance positions, wrapping at the capacity in use
   assign write_next  = (({1'b0, write_idx_ff} + LVL_W'(1)) >= capacity_ff) ?
                        '0 : write_idx_ff + IDX_W'(1);
   assign oldest_next = (({1'b0, oldest_idx_ff} + LVL_W'(1)) >= capacity_ff) ?
                        '0 : oldest_idx_ff + IDX_W'(1);

   // Peek addresses: a sum and one conditional subtract of the capacity each
   assign cap_wide   = (IDX_W+2)'(capacity_ff);
   assign newest_sum = (IDX_W+2)'(write_idx_ff) + cap_wide - (IDX_W+2)'(1)
                       - (IDX_W+2)'(req_data.offset);
   assign oldest_sum = (IDX_W+2)'(oldest_idx_ff) + (IDX_W+2)'(req_data.offset);

   assign out_of_range = (LVL_W'(req_data.offset) >= fill_ff);
   assign is_full      = (fill_ff >= capacity_ff);

   // Clamp a written capacity into 1..DEPTH
   always_comb begin
      if (csr_wr_data == '0) begin
         cap_clamped = LVL_W'(1);
      end else if (csr_wr_data > LVL_W'(DEPTH)) begin
         cap_clamped = LVL_W'(DEPTH);
      end else begin
         cap_clamped = csr_wr_data;
      end
   end

   // Decode the beat: pointer updates, memory access, response fields
   always_comb begin
      capacity_in   = capacity_ff;
      write_idx_in  = write_idx_ff;
      oldest_idx_in = oldest_idx_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_in        = rsp_ff;
      rsp_mem_in    = rsp_mem_ff;
      mem_wr        = 1'b0;
      mem_rd        = 1'b0;
      rd_addr       = '0;

      if (req_fire) begin
         rsp_valid_in         = 1'b1;
         rsp_mem_in           = 1'b0;
         rsp_in.read_data     = '0;
         rsp_in.status        = 1'b0;
         rsp_in.overwrote     = 1'b0;
         rsp_in.fill_level    = fill_ff;
         case (op)
            OP_PUSH: begin
               mem_wr       = 1'b1;
               write_idx_in = write_next;
               if (is_full) begin
                  oldest_idx_in    = oldest_next;
                  rsp_in.overwrote = 1'b1;
               end else begin
                  fill_in = fill_ff + LVL_W'(1);
               end
               rsp_in.fill_level = is_full ? fill_ff : fill_ff + LVL_W'(1);
            end
            OP_PEEK_NEWEST: begin
               if (out_of_range) begin
                  rsp_in.status = 1'b1;
               end else begin
                  mem_rd     = 1'b1;
                  rsp_mem_in = 1'b1;
                  rd_addr    = (newest_sum >= cap_wide) ?
                               IDX_W'(newest_sum - cap_wide) : IDX_W'(newest_sum);
               end
            end
            OP_PEEK_OLDEST: begin
               if (out_of_range) begin
                  rsp_in.status = 1'b1;
               end else begin
                  mem_rd     = 1'b1;
                  rsp_mem_in = 1'b1;
                  rd_addr    = (oldest_sum >= cap_wide) ?
                               IDX_W'(oldest_sum - cap_wide) : IDX_W'(oldest_sum);
               end
            end
            default: begin
               // unused code: report the level, change nothing
            end
         endcase
      end

      // Capacity write empties the buffer
      if (csr_wr_en) begin
         capacity_in   = cap_clamped;
         write_idx_in  = '0;
         oldest_idx_in = '0;
         fill_in       = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= LVL_W'(DEPTH);
         write_idx_ff  <= '0;
         oldest_idx_ff <= '0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         capacity_ff   <= capacity_in;
         write_idx_ff  <= write_idx_in;
         oldest_idx_ff <= oldest_idx_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Response payload, no reset
   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      rsp_mem_ff <= rsp_mem_in;
   end

   // Sample memory: one write or one read per cycle
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[write_idx_ff] <= req_data.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Drive the response beat
   always_comb begin
      rsp_data           = rsp_ff;
      rsp_data.read_data = rsp_mem_ff ? rd_data_ff : '0;
   end
   assign rsp_valid = rsp_valid_ff;

`include "overwrite_ring_buffer_peek_top_defines.svh"

   `ORBP_ASSERT_NOW(a_fill_le_cap, clock, reset, 1'b1, fill_ff <= capacity_ff,
      "fill level above capacity")
   `ORBP_ASSERT_NOW(a_idx_in_cap, clock, reset, 1'b1,
      ({1'b0, write_idx_ff} < capacity_ff) && ({1'b0, oldest_idx_ff} < capacity_ff),
      "buffer position outside capacity")
   `ORBP_ASSERT_NEXT(a_push_grows, clock, reset,
      req_fire && (op == OP_PUSH) && !is_full && !csr_wr_en,
      fill_ff == $past(fill_ff) + LVL_W'(1), "push did not raise fill level")
   `ORBP_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid_ff && rsp_ff.status,
      !rsp_mem_ff && (rsp_data.read_data == '0), "out-of-range peek returned data")

endmodule

`default_nettype wire
